// File: rtl/core/rctl_pkg.sv
// ----------------------------------------------------------------------------
// rctl_pkg: shared types and constants of the throttle light controller
// Holds the command codes, the configuration bundle and the result word.
// ----------------------------------------------------------------------------
package rctl_pkg;

  localparam int unsigned PWM_PERIOD      = 31;
  localparam int unsigned FLAME_BIT_TICKS = 64;
  localparam int unsigned TAIL_FULL       = 32;
  localparam int unsigned FLAME_BITS      = 7;
  localparam int unsigned PWM_W           = $clog2(PWM_PERIOD + 1);

  localparam logic [7:0] RST_NEUTRAL_WIDTH = 8'd188;
  localparam logic [7:0] RST_FULL_WIDTH    = 8'd250;
  localparam logic [5:0] RST_NEUTRAL_BAND  = 6'd6;
  localparam logic [6:0] RST_GLITCH_LIMIT  = 7'd3;
  localparam logic [7:0] RST_HEAT_MAX      = 8'd200;
  localparam logic [7:0] RST_HEAT_IGNITE   = 8'd100;
  localparam logic [7:0] RST_TAIL_DIM      = 8'd8;

  typedef enum logic [2:0] {
    REG_NEUTRAL_WIDTH     = 3'd0,
    REG_FULL_WIDTH        = 3'd1,
    REG_NEUTRAL_BAND      = 3'd2,
    REG_GLITCH_LIMIT      = 3'd3,
    REG_HEAT_MAX          = 3'd4,
    REG_HEAT_IGNITE       = 3'd5,
    REG_BACKFIRE_PATTERNS = 3'd6,
    REG_TAIL_DIM          = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    DRV_IDLE    = 2'd0,
    DRV_FORWARD = 2'd1,
    DRV_BRAKE   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0]  neutral_width;
    logic [7:0]  full_width;
    logic [5:0]  neutral_band;
    logic [6:0]  glitch_limit;
    logic [7:0]  heat_max;
    logic [7:0]  heat_ignite;
    logic [31:0] backfire_patterns;
    logic [7:0]  tail_dim;
  } cfg_t;

  // decoded throttle word handed to the lamp logic
  typedef struct packed {
    cmd_t command;
    logic hot;
  } thr_dec_t;

  typedef struct packed {
    logic       tail_on;
    logic       reverse_on;
    logic       flame_on;
    logic [1:0] throttle_command;
    logic [7:0] heat_level;
  } result_t;

endpackage

// File: rtl/core/rctl_throttle.sv
// ----------------------------------------------------------------------------
// rctl_throttle: throttle decoder
// Dead band test, signed glitch counter and command decision per word.
// ----------------------------------------------------------------------------
module rctl_throttle import rctl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       advance,
  input  logic       pulse_valid,
  input  logic [7:0] pulse_width,
  output thr_dec_t   dec
);

  logic signed [7:0] glitch_counter, glitch_counter_next;
  cmd_t              last_command, last_command_next;

  logic              reversed;
  logic [7:0]        diff;
  logic [7:0]        thr;
  logic [8:0]        upper_edge;
  logic [8:0]        width_plus_band;
  logic              above, below;
  logic signed [7:0] lim_pos, lim_neg;

  always_comb begin
    reversed        = cfg.full_width < cfg.neutral_width;
    diff            = reversed ? (cfg.neutral_width - cfg.full_width)
                               : (cfg.full_width - cfg.neutral_width);
    thr             = reversed ? (cfg.neutral_width - (diff >> 1))
                               : (cfg.neutral_width + (diff >> 1));
    upper_edge      = {1'b0, cfg.neutral_width} + {3'b000, cfg.neutral_band};
    width_plus_band = {1'b0, pulse_width} + {3'b000, cfg.neutral_band};
    above           = {1'b0, pulse_width} > upper_edge;
    // lower edge tested without going below zero
    below           = width_plus_band < {1'b0, cfg.neutral_width};
    lim_pos         = $signed({1'b0, cfg.glitch_limit});
    lim_neg         = -lim_pos;

    glitch_counter_next = glitch_counter;
    last_command_next   = last_command;
    if (pulse_valid) begin
      priority if (above) begin
        if (glitch_counter < lim_pos) begin
          glitch_counter_next = glitch_counter + 8'sd1;
          last_command_next   = DRV_IDLE;
        end else begin
          last_command_next   = reversed ? DRV_BRAKE : DRV_FORWARD;
        end
      end else if (below) begin
        if (glitch_counter > lim_neg) begin
          glitch_counter_next = glitch_counter - 8'sd1;
          last_command_next   = DRV_IDLE;
        end else begin
          last_command_next   = reversed ? DRV_FORWARD : DRV_BRAKE;
        end
      end else begin
        glitch_counter_next = '0;
        last_command_next   = DRV_IDLE;
      end
    end

    dec.command = last_command_next;
    dec.hot     = reversed ? (pulse_width < thr) : (pulse_width > thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_counter <= '0;
      last_command   <= DRV_IDLE;
    end else if (advance) begin
      glitch_counter <= glitch_counter_next;
      last_command   <= last_command_next;
    end
  end

endmodule

// File: rtl/core/rctl_lamps.sv
// ----------------------------------------------------------------------------
// rctl_lamps: lamp and exhaust state
// Reverse sequence, tail level, heat counter, flame shifter and tail pwm.
// ----------------------------------------------------------------------------
module rctl_lamps import rctl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       advance,
  input  logic       pulse_valid,
  input  logic [1:0] pattern_pick,
  input  thr_dec_t   dec,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_OFF    = 2'd0,
    PH_BRAKED = 2'd1,
    PH_ARMED  = 2'd2
  } phase_t;

  phase_t           reverse_phase, reverse_phase_next;
  logic             reverse_lamp, reverse_lamp_next;
  logic [7:0]       tail_level, tail_level_next;
  logic [7:0]       heat, heat_next;
  logic [7:0]       flame_pattern, flame_pattern_next;
  logic [2:0]       flame_bits_left, flame_bits_left_next;
  logic             flame_lamp, flame_lamp_next;
  logic [7:0]       flame_tick_count, flame_tick_count_next;
  logic [PWM_W-1:0] pwm_phase, pwm_phase_next;

  logic             cool;
  logic [PWM_W:0]   pwm_inc;

  always_comb begin
    reverse_phase_next   = reverse_phase;
    reverse_lamp_next    = reverse_lamp;
    tail_level_next      = tail_level;
    heat_next            = heat;
    flame_pattern_next   = flame_pattern;
    flame_bits_left_next = flame_bits_left;
    flame_lamp_next      = flame_lamp;
    cool                 = 1'b0;

    if (pulse_valid) begin
      unique case (dec.command)
        DRV_FORWARD: begin
          tail_level_next    = cfg.tail_dim;
          reverse_lamp_next  = 1'b0;
          reverse_phase_next = PH_OFF;
          if (dec.hot && (heat < cfg.heat_max)) begin
            heat_next = heat + 8'd1;
          end else if (heat != 8'd0) begin
            heat_next = heat - 8'd1;
          end
        end
        DRV_BRAKE: begin
          if (reverse_phase == PH_ARMED) begin
            reverse_lamp_next = 1'b1;
          end else begin
            tail_level_next    = 8'(TAIL_FULL);
            reverse_phase_next = PH_BRAKED;
          end
          cool = 1'b1;
        end
        default: begin
          tail_level_next = cfg.tail_dim;
          if (reverse_phase == PH_BRAKED) begin
            reverse_phase_next = PH_ARMED;
          end
          cool = 1'b1;
        end
      endcase
    end

    // leaving the throttle while hot loads a backfire pattern
    if (cool) begin
      if (heat >= cfg.heat_ignite) begin
        flame_pattern_next   = cfg.backfire_patterns[{pattern_pick, 3'b000} +: 8];
        flame_bits_left_next = 3'(FLAME_BITS);
        heat_next            = '0;
      end else if (heat != 8'd0) begin
        heat_next = heat - 8'd1;
      end
    end

    flame_tick_count_next = flame_tick_count - 8'd1;
    if (flame_tick_count_next == 8'd0) begin
      flame_tick_count_next = 8'(FLAME_BIT_TICKS);
      if (flame_bits_left_next != 3'd0) begin
        flame_bits_left_next = flame_bits_left_next - 3'd1;
        flame_lamp_next      = flame_pattern_next[0];
        flame_pattern_next   = flame_pattern_next >> 1;
      end
    end

    pwm_inc        = {1'b0, pwm_phase} + 1'b1;
    pwm_phase_next = (pwm_inc > (PWM_W + 1)'(PWM_PERIOD)) ? '0 : pwm_inc[PWM_W-1:0];

    res.tail_on          = tail_level_next > 8'(pwm_phase_next);
    res.reverse_on       = reverse_lamp_next;
    res.flame_on         = flame_lamp_next;
    res.throttle_command = dec.command;
    res.heat_level       = heat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_phase    <= PH_OFF;
      reverse_lamp     <= 1'b0;
      tail_level       <= RST_TAIL_DIM;
      heat             <= '0;
      flame_pattern    <= '0;
      flame_bits_left  <= '0;
      flame_lamp       <= 1'b0;
      flame_tick_count <= '0;
      pwm_phase        <= '0;
    end else if (advance) begin
      reverse_phase    <= reverse_phase_next;
      reverse_lamp     <= reverse_lamp_next;
      tail_level       <= tail_level_next;
      heat             <= heat_next;
      flame_pattern    <= flame_pattern_next;
      flame_bits_left  <= flame_bits_left_next;
      flame_lamp       <= flame_lamp_next;
      flame_tick_count <= flame_tick_count_next;
      pwm_phase        <= pwm_phase_next;
    end
  end

endmodule

// File: rtl/core/rctl_out_queue.sv
// ----------------------------------------------------------------------------
// rctl_out_queue: result buffer
// Two-word queue between the lamp logic and the output channel.
// ----------------------------------------------------------------------------
module rctl_out_queue import rctl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign can_push  = (count != 2'd2) || out_ready;
  assign out_word  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/rc_throttle_light_controller.sv
// ----------------------------------------------------------------------------
// rc_throttle_light_controller: throttle driven lamp controller, top level
// Path: input register, then the two-word result queue to the output.
// Throughput: one word per cycle while the queue can take a result, set by
// the single pass from input register to the two-word result queue.
// Reset: synchronous; registers return to their defaults, state clears.
// ----------------------------------------------------------------------------
module rc_throttle_light_controller import rctl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pulse_valid,
  input  logic [7:0]  pulse_width,
  input  logic [1:0]  pattern_pick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tail_on,
  output logic        reverse_on,
  output logic        flame_on,
  output logic [1:0]  throttle_command,
  output logic [7:0]  heat_level
);

  cfg_t       cfg;
  logic       stg_valid;
  logic       stg_pulse_valid;
  logic [7:0] stg_pulse_width;
  logic [1:0] stg_pick;
  logic       can_push;
  logic       advance;
  thr_dec_t   dec;
  result_t    res;
  result_t    out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral_width     <= RST_NEUTRAL_WIDTH;
      cfg.full_width        <= RST_FULL_WIDTH;
      cfg.neutral_band      <= RST_NEUTRAL_BAND;
      cfg.glitch_limit      <= RST_GLITCH_LIMIT;
      cfg.heat_max          <= RST_HEAT_MAX;
      cfg.heat_ignite       <= RST_HEAT_IGNITE;
      cfg.backfire_patterns <= '0;
      cfg.tail_dim          <= RST_TAIL_DIM;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_NEUTRAL_WIDTH:     cfg.neutral_width     <= cfg_data[7:0];
        REG_FULL_WIDTH:        cfg.full_width        <= cfg_data[7:0];
        REG_NEUTRAL_BAND:      cfg.neutral_band      <= cfg_data[5:0];
        REG_GLITCH_LIMIT:      cfg.glitch_limit      <= cfg_data[6:0];
        REG_HEAT_MAX:          cfg.heat_max          <= cfg_data[7:0];
        REG_HEAT_IGNITE:       cfg.heat_ignite       <= cfg_data[7:0];
        REG_BACKFIRE_PATTERNS: cfg.backfire_patterns <= cfg_data;
        REG_TAIL_DIM:          cfg.tail_dim          <= cfg_data[7:0];
        default:               cfg.tail_dim          <= cfg.tail_dim;
      endcase
    end
  end

  // input register moves on whenever the queue can take its result
  assign advance  = stg_valid && can_push;
  assign in_ready = !stg_valid || can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_pulse_valid <= pulse_valid;
      stg_pulse_width <= pulse_width;
      stg_pick        <= pattern_pick;
    end
  end

  rctl_throttle u_throttle (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .pulse_valid (stg_pulse_valid),
    .pulse_width (stg_pulse_width),
    .dec         (dec)
  );

  rctl_lamps u_lamps (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .advance      (advance),
    .pulse_valid  (stg_pulse_valid),
    .pattern_pick (stg_pick),
    .dec          (dec),
    .res          (res)
  );

  rctl_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_word (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign tail_on          = out_word.tail_on;
  assign reverse_on       = out_word.reverse_on;
  assign flame_on         = out_word.flame_on;
  assign throttle_command = out_word.throttle_command;
  assign heat_level       = out_word.heat_level;

endmodule
